// ----- rtl/sdcrc_pkg.sv -----
// ----------------------------------------------------------------------------
// sdcrc_pkg
// Shared constants and types for the SD four-line data CRC16 generator.
// ----------------------------------------------------------------------------
package sdcrc_pkg;

    localparam int unsigned LANES     = 4;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned CRC_BYTES = (LANES * CRC_W) / 8;
    localparam int unsigned WORD_W    = LANES * CRC_W;
    localparam int unsigned BYTE_CNT_W = $clog2(CRC_BYTES);

    // x^16 + x^12 + x^5 + 1
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    typedef logic [CRC_W-1:0] lane_crc_t;
    typedef lane_crc_t [LANES-1:0] lane_crc_vec_t;

    typedef struct packed {
        logic advance;
        logic clear;
    } lane_ctrl_t;

endpackage

// ----- rtl/sdcrc_lane.sv -----
// ----------------------------------------------------------------------------
// sdcrc_lane
// One data line CRC16: folds two line bits per request, first bit first.
// ----------------------------------------------------------------------------
module sdcrc_lane (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sdcrc_pkg::lane_ctrl_t   ctrl,
    input  logic [1:0]              line_bits,
    output sdcrc_pkg::lane_crc_t    crc_next
);

    sdcrc_pkg::lane_crc_t crc_reg;
    sdcrc_pkg::lane_crc_t seed;
    sdcrc_pkg::lane_crc_t mid;

    function automatic sdcrc_pkg::lane_crc_t crc_step(input sdcrc_pkg::lane_crc_t c,
                                                      input logic d);
        logic fb;
        fb = c[sdcrc_pkg::CRC_W-1] ^ d;
        crc_step = {c[sdcrc_pkg::CRC_W-2:0], 1'b0} ^ (fb ? sdcrc_pkg::CRC_POLY : '0);
    endfunction

    always_comb begin
        seed     = ctrl.clear ? '0 : crc_reg;
        mid      = crc_step(seed, line_bits[1]);
        crc_next = crc_step(mid, line_bits[0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
        end else if (ctrl.advance) begin
            crc_reg <= crc_next;
        end
    end

endmodule

// ----- rtl/sdcrc_merge.sv -----
// ----------------------------------------------------------------------------
// sdcrc_merge
// Interleaves the four lane CRCs into one 64-bit word and sends it out as
// eight bytes, most significant first.
// ----------------------------------------------------------------------------
module sdcrc_merge (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  sdcrc_pkg::lane_crc_vec_t    lane_crc,
    output logic                        busy,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_crc_byte,
    output logic                        m_crc_last
);

    logic [sdcrc_pkg::WORD_W-1:0]     packed_word;
    logic [sdcrc_pkg::WORD_W-1:0]     shift_reg;
    logic [sdcrc_pkg::WORD_W-1:0]     shift_next;
    logic [sdcrc_pkg::BYTE_CNT_W-1:0] cnt_reg;
    logic [sdcrc_pkg::BYTE_CNT_W-1:0] cnt_next;
    logic                             busy_reg;
    logic                             busy_next;
    logic                             at_last;

    // lane j bit k lands at bit 4k+j
    always_comb begin
        for (int k = 0; k < sdcrc_pkg::CRC_W; k++) begin
            for (int j = 0; j < sdcrc_pkg::LANES; j++) begin
                packed_word[k*sdcrc_pkg::LANES + j] = lane_crc[j][k];
            end
        end
    end

    assign at_last = (cnt_reg == sdcrc_pkg::BYTE_CNT_W'(sdcrc_pkg::CRC_BYTES - 1));

    always_comb begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (load) begin
            shift_next = packed_word;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg && m_ready) begin
            shift_next = {shift_reg[sdcrc_pkg::WORD_W-9:0], 8'h00};
            cnt_next   = cnt_reg + 1'b1;
            busy_next  = !at_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

    assign busy       = busy_reg;
    assign m_valid    = busy_reg;
    assign m_crc_byte = shift_reg[sdcrc_pkg::WORD_W-1 -: 8];
    assign m_crc_last = at_last;

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> !busy_reg)
        else $error("crc word loaded while previous word still going out");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_crc_last) |=> !busy_reg)
        else $error("output still busy after final crc byte");

    a_idle_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (cnt_reg == '0))
        else $error("byte counter not zero while idle");
`endif

endmodule

// ----- rtl/sd_four_line_data_crc16.sv -----
// ----------------------------------------------------------------------------
// sd_four_line_data_crc16
// CRC16 generator for the four data lines of an SD 4-bit bus.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one data byte per request, high nibble driven on the lines
//   first. s_first_byte clears all four line CRCs before the byte,
//   s_last_byte ends the block and queues the packed 64-bit CRC word.
//   m_ channel: eight CRC bytes per block, most significant first,
//   m_crc_last high on the eighth.
// latency and throughput:
//   one data byte per cycle while s_ready is high; the four line CRCs
//   advance in the accept cycle. the first CRC byte is valid the cycle
//   after the last data byte; the output register sends one byte per cycle
//   while m_ready is high. data bytes keep flowing while the word goes out;
//   a further last byte waits until the eighth CRC byte has been taken.
// reset:
//   clears all line CRCs and drops m_valid.
// stall:
//   with m_ready low the current CRC byte holds; data bytes without
//   s_last_byte are still accepted.
// ----------------------------------------------------------------------------
module sd_four_line_data_crc16 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_crc_byte,
    output logic        m_crc_last
);

    sdcrc_pkg::lane_ctrl_t    lane_ctrl;
    sdcrc_pkg::lane_crc_vec_t lane_crc;
    logic                     accept;
    logic                     busy;

    assign s_ready         = !busy || !s_last_byte;
    assign accept          = s_valid && s_ready;
    assign lane_ctrl.advance = accept;
    assign lane_ctrl.clear   = s_first_byte;

    for (genvar j = 0; j < sdcrc_pkg::LANES; j++) begin : g_lane
        sdcrc_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (lane_ctrl),
            .line_bits ({s_data_byte[sdcrc_pkg::LANES + j], s_data_byte[j]}),
            .crc_next  (lane_crc[j])
        );
    end

    sdcrc_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept && s_last_byte),
        .lane_crc   (lane_crc),
        .busy       (busy),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_crc_byte (m_crc_byte),
        .m_crc_last (m_crc_last)
    );

endmodule
